FILE: src/nca_pkg.sv
package nca_pkg;

   // Default build values
   localparam int unsigned MAX_CENTERS_DEF = 256;
   localparam int unsigned DIMENSIONS_DEF  = 2;

   // Field widths
   localparam int unsigned COORD_W = 16;
   localparam int unsigned INDEX_W = 8;
   localparam int unsigned COUNT_W = 9;
   localparam int unsigned SQ_W    = 32;
   localparam int unsigned DIST_W  = 33;

   // Searchable table depth: only slots 0..255 are addressable by a load
   localparam int unsigned SLOT_LIMIT = 256;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [INDEX_W-1:0]        index_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [DIST_W-1:0]         dist_type;

   // Function codes of an input item
   typedef enum logic {
      FUNC_LOAD     = 1'b0,
      FUNC_CLASSIFY = 1'b1
   } func_type;

   // Controller to datapath
   typedef struct packed {
      logic load;     // write the item's center into the table
      logic start;    // latch the point and rewind the scan address
      logic issue;    // read the next table entry into the pipeline
      logic publish;  // move the best match into the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic addr_last;  // the scan address is the last center to search
      logic busy;       // distance pipeline still holds entries
      logic rsp_free;   // result register can take a new result this cycle
   } status_type;

endpackage

FILE: src/nca_if.sv
interface nca_req_if;
   import nca_pkg::*;

   logic      valid;
   logic      ready;
   logic      func;
   index_type center_index;
   coord_type coord_x;
   coord_type coord_y;

   modport source (output valid, output func, output center_index,
                   output coord_x, output coord_y, input ready);
   modport sink   (input valid, input func, input center_index,
                   input coord_x, input coord_y, output ready);
endinterface

interface nca_rsp_if;
   import nca_pkg::*;

   logic      valid;
   logic      ready;
   index_type nearest_index;
   dist_type  min_distance;

   modport source (output valid, output nearest_index, output min_distance,
                   input ready);
   modport sink   (input valid, input nearest_index, input min_distance,
                   output ready);
endinterface

FILE: src/nca_ram.sv
module nca_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/nca_ctrl.sv
module nca_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_func,
   output logic                req_ready,
   input  nca_pkg::status_type status,
   output nca_pkg::cmd_type    cmd
);
   import nca_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PUBLISH
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // Take items only between classifications
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (func_type'(req_func) == FUNC_CLASSIFY) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.addr_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (status.rsp_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/nca_dp.sv
module nca_dp #(
   parameter int unsigned MAX_CENTERS = nca_pkg::MAX_CENTERS_DEF,
   parameter int unsigned DIMENSIONS  = nca_pkg::DIMENSIONS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  nca_pkg::cmd_type    cmd,
   output nca_pkg::status_type status,
   input  logic                csr_we,
   input  nca_pkg::count_type  csr_wdata,
   input  nca_pkg::index_type  req_center_index,
   input  nca_pkg::coord_type  req_coord_x,
   input  nca_pkg::coord_type  req_coord_y,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output nca_pkg::index_type  rsp_nearest_index,
   output nca_pkg::dist_type   rsp_min_distance
);
   import nca_pkg::*;

   localparam int unsigned TABLE_DEPTH = (MAX_CENTERS < SLOT_LIMIT) ? MAX_CENTERS : SLOT_LIMIT;
   localparam int unsigned ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned ENTRY_W     = COORD_W * DIMENSIONS;
   localparam int unsigned DIFF_W      = COORD_W + 1;

   // Search count, clamped to one and to the table depth on write
   count_type count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= count_type'(1);
      end else if (csr_we) begin
         if (csr_wdata == '0) begin
            count_ff <= count_type'(1);
         end else if (csr_wdata > count_type'(TABLE_DEPTH)) begin
            count_ff <= count_type'(TABLE_DEPTH);
         end else begin
            count_ff <= csr_wdata;
         end
      end
   end

   // Center table write side: drop loads beyond the table
   logic               tbl_we;
   logic [ENTRY_W-1:0] tbl_wdata;
   logic [ENTRY_W-1:0] tbl_rdata;
   logic [ADDR_W-1:0]  addr_ff;

   assign tbl_we = cmd.load && (32'(req_center_index) < MAX_CENTERS);

   if (DIMENSIONS > 1) begin : g_wr2
      assign tbl_wdata = {req_coord_x, req_coord_y};
   end else begin : g_wr1
      assign tbl_wdata = req_coord_x;
   end

   nca_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (req_center_index[ADDR_W-1:0]),
      .wdata (tbl_wdata),
      .re    (cmd.issue),
      .raddr (addr_ff),
      .rdata (tbl_rdata)
   );

   // Latch the point; walk the scan address
   coord_type px_ff, py_ff;
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         px_ff   <= req_coord_x;
         py_ff   <= req_coord_y;
         addr_ff <= '0;
      end else if (cmd.issue) begin
         addr_ff <= addr_ff + ADDR_W'(1);
      end
   end

   assign status.addr_last = (count_type'(addr_ff) == (count_ff - count_type'(1)));

   // Stage valids and index tags
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [ADDR_W-1:0] s1_idx_ff, s2_idx_ff, s3_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= addr_ff;
      s2_idx_ff <= s1_idx_ff;
      s3_idx_ff <= s2_idx_ff;
   end

   assign status.busy = s1_valid_ff || s2_valid_ff || s3_valid_ff;

   // Stage 1: coordinate differences as magnitudes
   logic signed [DIFF_W-1:0] dx;
   logic [COORD_W-1:0]       mag_x, mag_y;
   logic [COORD_W-1:0]       s2_mag_x_ff, s2_mag_y_ff;
   coord_type                cx;

   assign cx    = tbl_rdata[ENTRY_W-1 -: COORD_W];
   assign dx    = {px_ff[COORD_W-1], px_ff} - {cx[COORD_W-1], cx};
   assign mag_x = dx[DIFF_W-1] ? COORD_W'(-dx) : dx[COORD_W-1:0];

   if (DIMENSIONS > 1) begin : g_dy
      logic signed [DIFF_W-1:0] dy;
      coord_type                cy;
      assign cy    = tbl_rdata[COORD_W-1:0];
      assign dy    = {py_ff[COORD_W-1], py_ff} - {cy[COORD_W-1], cy};
      assign mag_y = dy[DIFF_W-1] ? COORD_W'(-dy) : dy[COORD_W-1:0];
   end else begin : g_nody
      assign mag_y = '0;
   end

   always_ff @(posedge clock) begin
      s2_mag_x_ff <= mag_x;
      s2_mag_y_ff <= mag_y;
   end

   // Stage 2: square each magnitude
   logic [SQ_W-1:0] s3_sq_x_ff, s3_sq_y_ff;
   always_ff @(posedge clock) begin
      s3_sq_x_ff <= s2_mag_x_ff * s2_mag_x_ff;
      s3_sq_y_ff <= s2_mag_y_ff * s2_mag_y_ff;
   end

   // Stage 3: sum and keep the best, lowest index wins ties
   dist_type          dist_sum;
   dist_type          best_d_ff;
   logic [ADDR_W-1:0] best_i_ff;

   assign dist_sum = DIST_W'(s3_sq_x_ff) + DIST_W'(s3_sq_y_ff);

   always_ff @(posedge clock) begin
      if (s3_valid_ff && ((s3_idx_ff == '0) || (dist_sum < best_d_ff))) begin
         best_d_ff <= dist_sum;
         best_i_ff <= s3_idx_ff;
      end
   end

   // Result register: hold until taken
   logic      rsp_valid_ff;
   index_type rsp_idx_ff;
   dist_type  rsp_dist_ff;

   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_idx_ff  <= INDEX_W'(best_i_ff);
         rsp_dist_ff <= best_d_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_idx_ff;
   assign rsp_min_distance  = rsp_dist_ff;

endmodule

FILE: src/nearest_center_assign.sv
// K-means assignment, two-dimensional unless DIMENSIONS is 1. A load item
// (func 0) writes one center, signed Q8.8 x and y, into table slot
// center_index and gives no result; slots at or beyond MAX_CENTERS are
// dropped. A classify item (func 1) searches the first num_centers slots (0
// counts as 1, larger values clamp to the table depth) and returns the
// lowest-indexed nearest center and its exact squared distance in unsigned
// Q17.16. Every searched slot must have been loaded first. One distance
// pipeline reads one table entry per cycle from a single RAM read port; a
// classify holds the block until its result moves to an output register, so
// the next item is taken while the result waits, and a classify stalls only
// at its end if the previous result has not been taken. The user must write
// num_centers through csr_we/csr_wdata while the block is idle; not enforced.
module nearest_center_assign #(
   parameter int unsigned MAX_CENTERS = nca_pkg::MAX_CENTERS_DEF,
   parameter int unsigned DIMENSIONS  = nca_pkg::DIMENSIONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   nca_req_if.sink            req_chan,
   nca_rsp_if.source          rsp_chan,
   input  logic               csr_we,
   input  nca_pkg::count_type csr_wdata
);
   import nca_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequence loads and classifications
   nca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Table, distance pipeline and result register
   nca_dp #(
      .MAX_CENTERS (MAX_CENTERS),
      .DIMENSIONS  (DIMENSIONS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_center_index  (req_chan.center_index),
      .req_coord_x       (req_chan.coord_x),
      .req_coord_y       (req_chan.coord_y),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_nearest_index (rsp_chan.nearest_index),
      .rsp_min_distance  (rsp_chan.min_distance)
   );

endmodule
